/* rtl/bmrc_pkg.sv */
package bmrc_pkg;

  // Default geometry
  localparam int unsigned BLOCK_BYTES_DEF = 16384;
  localparam int unsigned MAP_BITS_DEF    = 65536;

  // Field widths
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned ADDR_W = 13;
  localparam int unsigned VAL_W  = 8;
  localparam int unsigned PN_W   = 16;
  localparam int unsigned RNG_W  = 16;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned PL_W   = 25;
  localparam int unsigned TL_W   = 31;
  localparam int unsigned CFG_W  = 31;

  // Stream widths
  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 8;
  localparam int unsigned M_TUSER_W = 2;

  // Byte addresses reachable by a write
  localparam int unsigned ADDR_SPACE = 8192;

  // Dividend width of the block-count divider: piece length plus rounding term
  localparam int unsigned DIV_W = PL_W + 1;

  // Config reset values
  localparam logic [PL_W-1:0] PL_RESET = PL_W'(262144);
  localparam logic [TL_W-1:0] TL_RESET = TL_W'(1073741824);

  // Register indexes
  localparam logic CFG_PIECE_LENGTH = 1'b0;
  localparam logic CFG_TOTAL_LENGTH = 1'b1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PIECE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RANGE = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_ORDER  = 2'd1;
  localparam logic [ST_W-1:0] ST_BEYOND = 2'd2;

  // Walk span source
  localparam logic SRC_RANGE = 1'b0;
  localparam logic SRC_PIECE = 1'b1;

  // Divider operand select
  localparam logic DIV_PER_PIECE = 1'b0;
  localparam logic DIV_BLOCKS    = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic            load;
    logic            clr_en;
    logic            mem_write;
    logic            div_start;
    logic            div_sel;
    logic            mul1;
    logic            len_load;
    logic            pp_load;
    logic            mul2;
    logic            blk_load;
    logic            walk_init;
    logic            walk_src;
    logic            walk_step;
    logic            res_set;
    logic            res_use_walk;
    logic            res_all;
    logic [ST_W-1:0] res_st;
    logic            out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             wr_beyond;
    logic             rng_order;
    logic             rng_beyond;
    logic             pc_beyond;
    logic             blk_zero;
    logic             map_beyond;
    logic             div_done;
    logic             walk_last;
    logic             clr_last;
    logic             out_free;
  } status_t;

endpackage

/* rtl/bmrc_ram.sv */
module bmrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/bmrc_div.sv */
module bmrc_div #(
  parameter int unsigned DW      = 26,
  parameter int unsigned DIVISOR = 16384
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  // Reciprocal of the divisor: (x * RECIP) >> SH equals x / DIVISOR for every DW-bit x
  localparam int unsigned LW = $clog2(DIVISOR);
  localparam int unsigned SH = DW + LW;
  localparam int unsigned MW = DW + 2;
  localparam int unsigned PW = DW + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [DW-1:0] num_q;
  logic [DW-1:0] quo_q;
  logic          busy_q;
  logic          done_q;
  logic [PW-1:0] prod;

  assign prod = PW'(num_q) * PW'(RECIP);

  // Two stages: dividend register, then scaled product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      if (start_i) begin
        done_q <= 1'b0;
      end else if (busy_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
    end
    if (busy_q) begin
      quo_q <= DW'(prod >> SH);
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/bmrc_datapath.sv */
module bmrc_datapath #(
  parameter int unsigned BLOCK_BYTES = bmrc_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned MAP_BITS    = bmrc_pkg::MAP_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [bmrc_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic [bmrc_pkg::S_TDATA_W-1:0]  s_tdata_i,
  input  logic [bmrc_pkg::S_TUSER_W-1:0]  s_tuser_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [bmrc_pkg::M_TDATA_W-1:0]  m_tdata_o,
  output logic [bmrc_pkg::M_TUSER_W-1:0]  m_tuser_o,
  input  bmrc_pkg::cmd_t                  cmd_i,
  output bmrc_pkg::status_t               st_o
);

  localparam int unsigned STORE_BYTES = (MAP_BITS + 7) / 8;
  localparam int unsigned MEM_DEPTH   = (STORE_BYTES < bmrc_pkg::ADDR_SPACE) ?
                                        STORE_BYTES : bmrc_pkg::ADDR_SPACE;
  localparam int unsigned AW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned BW  = ($clog2(MAP_BITS) > 4) ? $clog2(MAP_BITS) : 4;
  localparam int unsigned BYW = BW - 3;
  localparam int unsigned DW  = bmrc_pkg::DIV_W;
  localparam int unsigned QW  = DW - $clog2(BLOCK_BYTES) + 1;
  localparam int unsigned SBW = bmrc_pkg::PN_W + bmrc_pkg::PL_W;
  localparam int unsigned FW  = bmrc_pkg::PN_W + QW;
  localparam int unsigned SW  = FW + 1;

  // Configuration registers
  logic [bmrc_pkg::PL_W-1:0] pl_q;
  logic [bmrc_pkg::TL_W-1:0] tl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pl_q <= bmrc_pkg::PL_RESET;
      tl_q <= bmrc_pkg::TL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bmrc_pkg::CFG_PIECE_LENGTH: pl_q <= cfg_wdata_i[bmrc_pkg::PL_W-1:0];
        bmrc_pkg::CFG_TOTAL_LENGTH: tl_q <= cfg_wdata_i[bmrc_pkg::TL_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture
  logic [bmrc_pkg::REQ_W-1:0]  rq_q;
  logic [bmrc_pkg::ADDR_W-1:0] addr_q;
  logic [bmrc_pkg::VAL_W-1:0]  val_q;
  logic [bmrc_pkg::PN_W-1:0]   pn_q;
  logic [bmrc_pkg::RNG_W-1:0]  rs_q;
  logic [bmrc_pkg::RNG_W-1:0]  re_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rq_q   <= s_tuser_i[1:0];
      addr_q <= s_tdata_i[12:0];
      val_q  <= s_tdata_i[20:13];
      pn_q   <= s_tdata_i[36:21];
      rs_q   <= s_tdata_i[52:37];
      re_q   <= s_tdata_i[68:53];
    end
  end

  // Clearing pass counter
  logic [AW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Block-count divider
  logic [DW-1:0] div_dividend;
  logic          div_done;
  logic [DW-1:0] div_quo;
  logic [bmrc_pkg::PL_W-1:0] this_len_q;

  assign div_dividend = ((cmd_i.div_sel == bmrc_pkg::DIV_BLOCKS) ?
                         DW'(this_len_q) : DW'(pl_q)) + DW'(BLOCK_BYTES - 1);

  bmrc_div #(
    .DW      (DW),
    .DIVISOR (BLOCK_BYTES)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Piece geometry
  logic [SBW-1:0] start_q;
  logic           start_ge_q;
  logic [SBW-1:0] left;
  logic [QW-1:0]  pp_q;
  logic [QW-1:0]  blocks_q;
  logic [FW-1:0]  first_q;
  logic [SW-1:0]  piece_end;

  assign left      = SBW'(tl_q) - start_q;
  assign piece_end = SW'(first_q) + SW'(blocks_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      start_q <= SBW'(pn_q) * SBW'(pl_q);
    end
    if (cmd_i.len_load) begin
      start_ge_q <= start_q >= SBW'(tl_q);
      this_len_q <= (left < SBW'(pl_q)) ? left[bmrc_pkg::PL_W-1:0] : pl_q;
    end
    if (cmd_i.pp_load) begin
      pp_q <= div_quo[QW-1:0];
    end
    if (cmd_i.mul2) begin
      first_q <= FW'(pn_q) * FW'(pp_q);
    end
    if (cmd_i.blk_load) begin
      blocks_q <= div_quo[QW-1:0];
    end
  end

  // Span walk: one bitmap byte per cycle
  logic [BW-1:0]  lo_q, hi_q, lo_d, hi_d;
  logic [BYW-1:0] cur_q, last_q;
  logic [7:0]     mask_d, mask_q;
  logic           chk_v_q, beyond_q, ok_q;
  logic [7:0]     rdata;
  logic           pass, walk_ok_now;

  always_comb begin
    if (cmd_i.walk_src == bmrc_pkg::SRC_PIECE) begin
      lo_d = first_q[BW-1:0];
      hi_d = BW'(piece_end - SW'(1));
    end else begin
      lo_d = BW'(rs_q);
      hi_d = BW'(re_q);
    end
  end

  // Bits of the current byte that lie inside the span
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      mask_d[j] = ((cur_q != lo_q[BW-1:3]) || (3'(j) >= lo_q[2:0])) &&
                  ((cur_q != hi_q[BW-1:3]) || (3'(j) <= hi_q[2:0]));
    end
  end

  // Bit index j of a byte sits at bit position 7-j
  always_comb begin
    pass = 1'b1;
    for (int j = 0; j < 8; j++) begin
      if (mask_q[j] && (beyond_q || !rdata[7-j])) begin
        pass = 1'b0;
      end
    end
  end

  assign walk_ok_now = ok_q & (~chk_v_q | pass);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_v_q <= 1'b0;
    end else begin
      chk_v_q <= cmd_i.walk_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      cur_q  <= lo_d[BW-1:3];
      last_q <= hi_d[BW-1:3];
      ok_q   <= 1'b1;
    end else begin
      if (cmd_i.walk_step) begin
        cur_q <= cur_q + 1'b1;
      end
      if (chk_v_q) begin
        ok_q <= ok_q & pass;
      end
    end
    mask_q   <= mask_d;
    beyond_q <= 32'(cur_q) >= 32'(MEM_DEPTH);
  end

  // Bitmap store
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  assign ram_we    = cmd_i.clr_en | cmd_i.mem_write;
  assign ram_waddr = cmd_i.clr_en ? clr_q : addr_q[AW-1:0];
  assign ram_wdata = cmd_i.clr_en ? 8'h00 : val_q;

  bmrc_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cur_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Result and output register
  logic                      res_all_q;
  logic [bmrc_pkg::ST_W-1:0] res_st_q;
  logic                      m_valid_q;
  logic                      m_all_q;
  logic [bmrc_pkg::ST_W-1:0] m_st_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_all_q <= cmd_i.res_use_walk ? walk_ok_now : cmd_i.res_all;
      res_st_q  <= cmd_i.res_st;
    end
    if (cmd_i.out_load) begin
      m_all_q <= res_all_q;
      m_st_q  <= res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {7'b0, m_all_q};
  assign m_tuser_o  = m_st_q;

  // Status to controller
  assign st_o.req        = rq_q;
  assign st_o.wr_beyond  = 32'(addr_q) >= 32'(STORE_BYTES);
  assign st_o.rng_order  = rs_q > re_q;
  assign st_o.rng_beyond = 32'(re_q) >= 32'(MAP_BITS);
  assign st_o.pc_beyond  = start_ge_q;
  assign st_o.blk_zero   = blocks_q == '0;
  assign st_o.map_beyond = piece_end > SW'(MAP_BITS);
  assign st_o.div_done   = div_done;
  assign st_o.walk_last  = cur_q == last_q;
  assign st_o.clr_last   = clr_q == AW'(MEM_DEPTH - 1);
  assign st_o.out_free   = ~m_valid_q | m_tready_i;

endmodule

/* rtl/bmrc_ctrl.sv */
module bmrc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  bmrc_pkg::status_t st_i,
  output bmrc_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_DIV1,
    S_DIV2,
    S_CHECK,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  assign s_tready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (st_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st_i.req)
          bmrc_pkg::REQ_WRITE: begin
            cmd_o.mem_write = ~st_i.wr_beyond;
            cmd_o.res_set   = 1'b1;
            cmd_o.res_st    = st_i.wr_beyond ? bmrc_pkg::ST_BEYOND : bmrc_pkg::ST_OK;
            state_d         = S_FINISH;
          end
          bmrc_pkg::REQ_PIECE: begin
            cmd_o.mul1      = 1'b1;
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = bmrc_pkg::DIV_PER_PIECE;
            state_d         = S_DIV1;
          end
          bmrc_pkg::REQ_RANGE: begin
            if (st_i.rng_order) begin
              cmd_o.res_set = 1'b1;
              cmd_o.res_st  = bmrc_pkg::ST_ORDER;
              state_d       = S_FINISH;
            end else if (st_i.rng_beyond) begin
              cmd_o.res_set = 1'b1;
              cmd_o.res_st  = bmrc_pkg::ST_BEYOND;
              state_d       = S_FINISH;
            end else begin
              cmd_o.walk_init = 1'b1;
              cmd_o.walk_src  = bmrc_pkg::SRC_RANGE;
              state_d         = S_WALK;
            end
          end
          default: begin
            cmd_o.res_set = 1'b1;
            cmd_o.res_st  = bmrc_pkg::ST_OK;
            state_d       = S_FINISH;
          end
        endcase
      end
      S_DIV1: begin
        cmd_o.len_load = 1'b1;
        if (st_i.div_done) begin
          cmd_o.pp_load = 1'b1;
          if (st_i.pc_beyond) begin
            cmd_o.res_set = 1'b1;
            cmd_o.res_st  = bmrc_pkg::ST_BEYOND;
            state_d       = S_FINISH;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = bmrc_pkg::DIV_BLOCKS;
            state_d         = S_DIV2;
          end
        end
      end
      S_DIV2: begin
        cmd_o.mul2 = 1'b1;
        if (st_i.div_done) begin
          cmd_o.blk_load = 1'b1;
          state_d        = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st_i.blk_zero) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_all = 1'b1;
          cmd_o.res_st  = bmrc_pkg::ST_OK;
          state_d       = S_FINISH;
        end else if (st_i.map_beyond) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_st  = bmrc_pkg::ST_BEYOND;
          state_d       = S_FINISH;
        end else begin
          cmd_o.walk_init = 1'b1;
          cmd_o.walk_src  = bmrc_pkg::SRC_PIECE;
          state_d         = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (st_i.walk_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last byte read is being checked this cycle
        cmd_o.res_set      = 1'b1;
        cmd_o.res_use_walk = 1'b1;
        cmd_o.res_st       = bmrc_pkg::ST_OK;
        state_d            = S_FINISH;
      end
      S_FINISH: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/bitmap_range_check_core.sv */
// Channel  | Direction | Signals                          | Contents
// s_axis   | in        | tvalid tready tdata[71:0] tuser  | request
// m_axis   | out       | tvalid tready tdata[7:0] tuser   | result
// cfg      | in        | cfg_we_i cfg_index_i cfg_wdata_i | register write
//
// One request at a time. A write, an unused request kind or a range error is answered
// straight after decode; a range query walks each bitmap byte it spans; a piece query runs
// two reciprocal divisions, then walks each byte of the piece, and ends early when the piece
// starts past the content (after the first division), is empty or lies beyond the bitmap.
// s_axis_tready rises with the result; a result not yet taken holds the next one.
// After reset a clearing pass zeroes the bitmap RAM, one byte per cycle
// (MAP_BITS/8 rounded up, at most 8192 bytes), while s_axis_tready stays low.
module bitmap_range_check_core #(
  parameter int unsigned BLOCK_BYTES = bmrc_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned MAP_BITS    = bmrc_pkg::MAP_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [bmrc_pkg::CFG_W-1:0]     cfg_wdata_i,
  // Request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // byte_address[12:0], byte_value[20:13], piece_idx[36:21],
  // range_start[52:37], range_end[68:53], zero fill [71:69]
  input  logic [bmrc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [bmrc_pkg::S_TUSER_W-1:0] s_axis_tuser,
  // Result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // all_set[0], zero fill [7:1]
  output logic [bmrc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [bmrc_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  bmrc_pkg::cmd_t    cmd;
  bmrc_pkg::status_t st;

  // Sequencer
  bmrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Bitmap store, geometry arithmetic and result register
  bmrc_datapath #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAP_BITS    (MAP_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule
